/* design/size_budget_lru_tracker_assert.svh */
// Assertion macros used by the size-budget LRU tracker module.
`ifndef SIZE_BUDGET_LRU_TRACKER_ASSERT_SVH
`define SIZE_BUDGET_LRU_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBLT_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("size_budget_lru_tracker: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("size_budget_lru_tracker: check failed");

`endif

/* design/sblt_pkg.sv */
// Shared types and constants of the size-budget LRU tracker.
package sblt_pkg;

    localparam int BLOCK_W     = 20;
    localparam int BYTES_W     = 25;
    localparam int SUM_W       = BYTES_W + 1;
    localparam int CMD_W       = 2;
    localparam int ENTRIES_DEF = 16;
    localparam int SLOT_W_MAX  = 6;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd2;

    localparam logic RES_EVICT = 1'b0;
    localparam logic RES_DONE  = 1'b1;

    localparam logic [BYTES_W-1:0] BUDGET_RESET = 25'd4194304;

    localparam logic [BLOCK_W-1:0] SEG_LO_BASE = 20'h80000;
    localparam logic [BLOCK_W-1:0] SEG_HI_BASE = 20'hA0000;
    localparam logic [BLOCK_W-1:0] SEG_TOP     = 20'hC0000;
    localparam logic [BLOCK_W-1:0] SEG_STEP    = 20'h20000;

    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [BYTES_W-1:0] bytes;
    } t_entry;

    // Rotation request for the recency order table. A right rotation covers
    // positions 0..idx, a left rotation covers idx..lim.
    typedef struct packed {
        logic                  en;
        logic                  left;
        logic [SLOT_W_MAX-1:0] lim;
    } t_rot_ctl;

endpackage

/* design/size_budget_lru_tracker.sv */
// Size-budget LRU tracker: one transaction in flight, results one per output transaction.
// Keeps up to ENTRIES blocks in recency order under a byte budget and reports each eviction
// and one completion per command. Commands are handled one at a time by a sequencer around a
// single entry RAM read port. Allocate computes the bytes over budget, then for each eviction
// that the budget forces runs address, compare and recheck, then evicts one more entry if the
// table is still full, then inserts. Free reads and compares entries from the most recent end
// up to and including the first match, or every valid entry when nothing matches. Touch reads
// and compares every valid entry. An unknown command, or free or touch on an empty table, goes
// straight to the completion. A new command is accepted in the cycle after the last result is
// registered. A stalled output adds its stall cycles. No clearing pass is needed after reset;
// the budget register may be written while the block is idle.
`include "size_budget_lru_tracker_assert.svh"

module size_budget_lru_tracker
    import sblt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [BLOCK_W-1:0] i_block_number,
    input  logic [BYTES_W-1:0] i_block_size,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_result_kind,
    output logic [BLOCK_W-1:0] o_result_block,
    output logic               o_found,
    output logic [BYTES_W-1:0] o_bytes_in_use,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [BYTES_W-1:0] i_cfg_byte_budget
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_NEED    = 4'd1;
    localparam logic [3:0] S_EV_CHK  = 4'd2;
    localparam logic [3:0] S_EV_RD   = 4'd3;
    localparam logic [3:0] S_EV_CMP  = 4'd4;
    localparam logic [3:0] S_INS     = 4'd5;
    localparam logic [3:0] S_FR_RD   = 4'd6;
    localparam logic [3:0] S_FR_CMP  = 4'd7;
    localparam logic [3:0] S_TC_RD   = 4'd8;
    localparam logic [3:0] S_TC_CMP  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]         r_state, n_state;
    logic [BLOCK_W-1:0] r_blk, n_blk;
    logic [BYTES_W-1:0] r_size, n_size;
    logic [SUM_W-1:0]   r_total, n_total;
    logic [SUM_W-1:0]   r_need, n_need;
    logic [BYTES_W-1:0] r_used, n_used;
    logic [BYTES_W-1:0] r_budget;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    logic [SW-1:0]      r_ptr, n_ptr;
    logic               r_found, n_found;
    logic               r_fin, n_fin;
    logic               r_has_alias, n_has_alias;
    logic [BLOCK_W-1:0] r_alias, n_alias;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [BLOCK_W-1:0] r_out_block;
    logic               r_out_found;
    logic [BYTES_W-1:0] r_out_bytes;
    logic               r_out_last;

    logic               w_emit;
    logic               w_em_kind;
    logic [BLOCK_W-1:0] w_em_block;
    logic               w_em_found;
    logic [BYTES_W-1:0] w_em_bytes;
    logic               w_em_last;

    logic               w_slot_free;
    logic [SW-1:0]      w_slot;
    t_rot_ctl           w_rot;
    logic               w_we;
    logic [$bits(t_entry)-1:0] w_ram_rdata;
    t_entry             w_rd;
    t_entry             w_wr;

    logic [SUM_W-1:0]   w_sum_ins;
    logic [BYTES_W-1:0] w_used_ins;
    logic [BYTES_W-1:0] w_used_sub;
    logic [SUM_W-1:0]   w_rd_bytes_ext;
    logic [SUM_W-1:0]   w_need_sub;
    logic [SUM_W-1:0]   w_budget_ext;
    logic [SUM_W-1:0]   w_need_new;
    logic               w_hit;
    logic               w_hit_any;
    logic [CW-1:0]      w_count_m1;

    sblt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (w_wr),
        .i_raddr (w_slot),
        .o_rdata (w_ram_rdata)
    );

    sblt_order #(
        .ENTRIES (ENTRIES)
    ) u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_ptr),
        .i_rot   (w_rot),
        .o_slot  (w_slot)
    );

    assign w_rd        = t_entry'(w_ram_rdata);
    assign w_wr.block  = r_blk;
    assign w_wr.bytes  = r_size;
    assign w_slot_free = !r_out_valid || i_res_ready;
    assign w_count_m1  = r_count - CW'(1);

    // Byte arithmetic: saturating add on insert, flooring subtracts on removal.
    assign w_sum_ins      = {1'b0, r_used} + {1'b0, r_size};
    assign w_used_ins     = w_sum_ins[SUM_W-1] ? '1 : w_sum_ins[BYTES_W-1:0];
    assign w_used_sub     = (r_used > w_rd.bytes) ? (r_used - w_rd.bytes) : '0;
    assign w_rd_bytes_ext = {1'b0, w_rd.bytes};
    assign w_need_sub     = (r_need > w_rd_bytes_ext) ? (r_need - w_rd_bytes_ext) : '0;
    assign w_budget_ext   = {1'b0, r_budget};
    assign w_need_new     = (r_total > w_budget_ext) ? (r_total - w_budget_ext) : '0;

    assign w_hit     = (w_rd.block == r_blk);
    assign w_hit_any = w_hit || (r_has_alias && (w_rd.block == r_alias));

    always_comb begin
        n_state     = r_state;
        n_blk       = r_blk;
        n_size      = r_size;
        n_total     = r_total;
        n_need      = r_need;
        n_used      = r_used;
        n_count     = r_count;
        n_left      = r_left;
        n_ptr       = r_ptr;
        n_found     = r_found;
        n_fin       = r_fin;
        n_has_alias = r_has_alias;
        n_alias     = r_alias;
        w_rot       = '0;
        w_we        = 1'b0;
        w_emit      = 1'b0;
        w_em_kind   = RES_DONE;
        w_em_block  = r_blk;
        w_em_found  = 1'b0;
        w_em_bytes  = r_used;
        w_em_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_blk       = i_block_number;
                    n_size      = i_block_size;
                    n_total     = {1'b0, r_used} + {1'b0, i_block_size};
                    n_found     = 1'b0;
                    n_fin       = 1'b0;
                    n_has_alias = 1'b0;
                    n_alias     = i_block_number;
                    if (i_block_number >= SEG_LO_BASE && i_block_number < SEG_HI_BASE) begin
                        n_has_alias = 1'b1;
                        n_alias     = i_block_number + SEG_STEP;
                    end else if (i_block_number >= SEG_HI_BASE && i_block_number < SEG_TOP) begin
                        n_has_alias = 1'b1;
                        n_alias     = i_block_number - SEG_STEP;
                    end
                    unique case (i_command)
                        CMD_ALLOC: begin
                            n_state = S_NEED;
                        end
                        CMD_FREE: begin
                            n_ptr   = '0;
                            n_state = (r_count == '0) ? S_DONE : S_FR_RD;
                        end
                        CMD_TOUCH: begin
                            n_ptr   = SW'(w_count_m1);
                            n_left  = r_count;
                            n_state = (r_count == '0) ? S_DONE : S_TC_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_NEED: begin
                n_need  = w_need_new;
                n_state = S_EV_CHK;
            end
            S_EV_CHK: begin
                if (r_need != '0 && r_count != '0) begin
                    n_ptr   = SW'(w_count_m1);
                    n_state = S_EV_RD;
                end else if (r_count == CW'(ENTRIES)) begin
                    // Still full once the budget is met: one more goes.
                    n_ptr   = SW'(w_count_m1);
                    n_fin   = 1'b1;
                    n_state = S_EV_RD;
                end else begin
                    n_ptr   = SW'(r_count);
                    n_state = S_INS;
                end
            end
            S_EV_RD: begin
                n_state = S_EV_CMP;
            end
            S_EV_CMP: begin
                if (w_slot_free) begin
                    w_emit     = 1'b1;
                    w_em_kind  = RES_EVICT;
                    w_em_block = w_rd.block;
                    w_em_bytes = w_used_sub;
                    w_em_last  = 1'b0;
                    n_used     = w_used_sub;
                    n_need     = w_need_sub;
                    n_count    = w_count_m1;
                    // The pointer now names the slot just past the new count.
                    n_state    = r_fin ? S_INS : S_EV_CHK;
                end
            end
            S_INS: begin
                if (w_slot_free) begin
                    w_we       = 1'b1;
                    w_rot.en   = 1'b1;
                    n_count    = r_count + CW'(1);
                    n_used     = w_used_ins;
                    w_emit     = 1'b1;
                    w_em_bytes = w_used_ins;
                    n_state    = S_IDLE;
                end
            end
            S_FR_RD: begin
                n_state = S_FR_CMP;
            end
            S_FR_CMP: begin
                if (w_hit) begin
                    if (w_slot_free) begin
                        w_rot.en   = 1'b1;
                        w_rot.left = 1'b1;
                        w_rot.lim  = SLOT_W_MAX'(w_count_m1);
                        n_count    = w_count_m1;
                        n_used     = w_used_sub;
                        w_emit     = 1'b1;
                        w_em_found = 1'b1;
                        w_em_bytes = w_used_sub;
                        n_state    = S_IDLE;
                    end
                end else if (r_ptr == SW'(w_count_m1)) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr   = r_ptr + SW'(1);
                    n_state = S_FR_RD;
                end
            end
            S_TC_RD: begin
                n_state = S_TC_CMP;
            end
            S_TC_CMP: begin
                // Scanning from the least recent end and moving each match to
                // the front keeps the matches in their original order.
                if (w_hit_any) begin
                    w_rot.en = 1'b1;
                    n_found  = 1'b1;
                end else if (r_ptr != '0) begin
                    n_ptr = r_ptr - SW'(1);
                end
                n_left  = r_left - CW'(1);
                n_state = (r_left == CW'(1)) ? S_DONE : S_TC_RD;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    w_emit     = 1'b1;
                    w_em_found = r_found;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_count <= '0;
            r_fin   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_count <= n_count;
            r_fin   <= n_fin;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk       <= n_blk;
        r_size      <= n_size;
        r_total     <= n_total;
        r_need      <= n_need;
        r_left      <= n_left;
        r_ptr       <= n_ptr;
        r_has_alias <= n_has_alias;
        r_alias     <= n_alias;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
        end else if (i_cfg_valid) begin
            r_budget <= i_cfg_byte_budget;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind  <= w_em_kind;
            r_out_block <= w_em_block;
            r_out_found <= w_em_found;
            r_out_bytes <= w_em_bytes;
            r_out_last  <= w_em_last;
        end
    end

    assign o_cmd_ready    = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_res_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_result_block = r_out_block;
    assign o_found        = r_out_found;
    assign o_bytes_in_use = r_out_bytes;
    assign o_last         = r_out_last;

    `SBLT_ASSERT_HOLD(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES))
    `SBLT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_cmd_valid && o_cmd_ready, r_state != S_IDLE)
    `SBLT_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_emit && w_em_last, r_state == S_IDLE)
    `SBLT_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, r_state == S_INS && w_slot_free, r_count == $past(r_count) + CW'(1))
    `SBLT_ASSERT_HOLD(a_evict_nonempty, i_clk, i_rst_n, r_state == S_EV_CMP, r_count != '0)

endmodule

/* design/sblt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/sblt_order.sv */
// Recency order table: a permutation of slots, position 0 most recent.
module sblt_order
    import sblt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [$clog2(ENTRIES)-1:0] i_idx,
    input  t_rot_ctl                   i_rot,
    output logic [$clog2(ENTRIES)-1:0] o_slot
);

    localparam int SW = $clog2(ENTRIES);

    logic [SW-1:0] r_order [ENTRIES];
    logic [SW-1:0] w_slot;
    logic [SW-1:0] w_lim;

    assign w_slot = r_order[i_idx];
    assign w_lim  = i_rot.lim[SW-1:0];
    assign o_slot = w_slot;

    // Positions past the valid count always hold the free slots, so an
    // insert takes the slot just past the count.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        localparam logic [SW-1:0] POS = SW'(g);
        logic [SW-1:0] w_prev;
        logic [SW-1:0] w_next;
        logic          w_in_right;
        logic          w_in_left;

        if (g == 0) begin : g_first
            assign w_prev = w_slot;
        end else begin : g_mid_prev
            assign w_prev = r_order[g-1];
        end

        if (g == ENTRIES - 1) begin : g_last
            assign w_next = w_slot;
        end else begin : g_mid_next
            assign w_next = (POS == w_lim) ? w_slot : r_order[g+1];
        end

        assign w_in_right = i_rot.en && !i_rot.left && (POS <= i_idx);
        assign w_in_left  = i_rot.en && i_rot.left && (POS >= i_idx) && (POS <= w_lim);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_order[g] <= POS;
            end else if (w_in_right) begin
                r_order[g] <= (POS == '0) ? w_slot : w_prev;
            end else if (w_in_left) begin
                r_order[g] <= w_next;
            end
        end
    end

endmodule

/* test/size_budget_lru_tracker_test.sv */
// Randomized self-checking testbench for the size-budget LRU tracker.
`timescale 1ns / 1ps

module size_budget_lru_tracker_test;
    import sblt_pkg::*;

    localparam int SLOTS       = ENTRIES_DEF;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 48;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_REPORTS = 10;

    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [BYTES_W-1:0] BYTES_MAX  = {BYTES_W{1'b1}};

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [BLOCK_W-1:0] blk;
        logic [BYTES_W-1:0] size;
    } cmd_item_t;

    typedef struct {
        logic               kind;
        logic [BLOCK_W-1:0] blk;
        logic               found;
        logic [BYTES_W-1:0] bytes;
        logic               last;
    } report_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cmd_valid = 1'b0;
    logic               o_cmd_ready;
    logic [CMD_W-1:0]   i_command = CMD_ALLOC;
    logic [BLOCK_W-1:0] i_block_number = '0;
    logic [BYTES_W-1:0] i_block_size = '0;
    logic               o_res_valid;
    logic               i_res_ready = 1'b0;
    logic               o_result_kind;
    logic [BLOCK_W-1:0] o_result_block;
    logic               o_found;
    logic [BYTES_W-1:0] o_bytes_in_use;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [BYTES_W-1:0] i_cfg_byte_budget = BUDGET_RESET;

    size_budget_lru_tracker dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (i_cmd_valid),
        .o_cmd_ready       (o_cmd_ready),
        .i_command         (i_command),
        .i_block_number    (i_block_number),
        .i_block_size      (i_block_size),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_result_kind     (o_result_kind),
        .o_result_block    (o_result_block),
        .o_found           (o_found),
        .o_bytes_in_use    (o_bytes_in_use),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_byte_budget (i_cfg_byte_budget)
    );

    always #2 i_clk = ~i_clk;

    cmd_item_t pending_cmds[$];
    report_t   expected_reports[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        idling_on = 1'b1;
    int        holds_wanted = 0;
    int        holds_started = 0;
    logic [BLOCK_W-1:0] block_pool[POOL_SIZE];

    // Tracker state as the testbench sees it.
    logic [BLOCK_W-1:0] slot_block[SLOTS];
    logic [BYTES_W-1:0] slot_bytes[SLOTS];
    bit                 slot_live[SLOTS];
    int                 slot_rank[SLOTS];
    logic [BYTES_W-1:0] bytes_held = '0;
    logic [BYTES_W-1:0] budget_limit = BUDGET_RESET;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_block[i] = '0;
            slot_bytes[i] = '0;
            slot_live[i]  = 1'b0;
            slot_rank[i]  = 0;
        end
    end

    function automatic int live_count();
        int n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i])
                n++;
        return n;
    endfunction

    function automatic void note_report(logic kind, logic [BLOCK_W-1:0] blk, logic found,
                                        logic last);
        report_t r;
        r.kind  = kind;
        r.blk   = blk;
        r.found = found;
        r.bytes = bytes_held;
        r.last  = last;
        expected_reports.push_back(r);
    endfunction

    function automatic void drop_slot(int idx);
        int r = slot_rank[idx];
        slot_live[idx] = 1'b0;
        for (int j = 0; j < SLOTS; j++)
            if (slot_live[j] && slot_rank[j] > r)
                slot_rank[j]--;
        bytes_held = (bytes_held > slot_bytes[idx]) ? bytes_held - slot_bytes[idx] : '0;
    endfunction

    // Removes the least recent entry, reports it and returns its size.
    function automatic logic [BYTES_W-1:0] evict_oldest();
        int sel = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && (sel < 0 || slot_rank[i] > slot_rank[sel]))
                sel = i;
        if (sel < 0)
            return '0;
        drop_slot(sel);
        note_report(RES_EVICT, slot_block[sel], 1'b0, 1'b0);
        return slot_bytes[sel];
    endfunction

    function automatic void predict_command(cmd_item_t it);
        logic [BYTES_W+1:0] total;
        logic [BYTES_W+1:0] need;
        logic [BYTES_W-1:0] freed;
        logic [BLOCK_W-1:0] alias_blk;
        bit                 has_alias;
        bit                 hit[SLOTS];
        int                 new_rank[SLOTS];
        int                 hits;
        int                 sel;

        case (it.cmd)
            CMD_ALLOC: begin
                total = bytes_held + it.size;
                if (total > budget_limit) begin
                    need = total - budget_limit;
                    while (need > 0 && live_count() > 0) begin
                        freed = evict_oldest();
                        need = (need > freed) ? need - freed : '0;
                    end
                end
                if (live_count() >= SLOTS)
                    void'(evict_oldest());
                sel = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_live[i] && sel < 0)
                        sel = i;
                if (sel >= 0) begin
                    for (int j = 0; j < SLOTS; j++)
                        if (slot_live[j])
                            slot_rank[j]++;
                    slot_live[sel]  = 1'b1;
                    slot_rank[sel]  = 0;
                    slot_block[sel] = it.blk;
                    slot_bytes[sel] = it.size;
                    total = bytes_held + it.size;
                    bytes_held = (total > BYTES_MAX) ? BYTES_MAX : total[BYTES_W-1:0];
                end
                note_report(RES_DONE, it.blk, 1'b0, 1'b1);
            end
            CMD_FREE: begin
                // Only the most recent of several equal block numbers goes.
                sel = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && slot_block[i] == it.blk &&
                        (sel < 0 || slot_rank[i] < slot_rank[sel]))
                        sel = i;
                if (sel >= 0)
                    drop_slot(sel);
                note_report(RES_DONE, it.blk, sel >= 0, 1'b1);
            end
            CMD_TOUCH: begin
                has_alias = 1'b0;
                alias_blk = '0;
                if (it.blk >= SEG_LO_BASE && it.blk < SEG_HI_BASE) begin
                    has_alias = 1'b1;
                    alias_blk = it.blk + SEG_STEP;
                end else if (it.blk >= SEG_HI_BASE && it.blk < SEG_TOP) begin
                    has_alias = 1'b1;
                    alias_blk = it.blk - SEG_STEP;
                end
                hits = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    hit[i] = slot_live[i] && (slot_block[i] == it.blk ||
                                              (has_alias && slot_block[i] == alias_blk));
                    if (hit[i])
                        hits++;
                end
                // Matches move to the front in their old order; the rest follow them.
                for (int i = 0; i < SLOTS; i++) begin
                    new_rank[i] = slot_rank[i];
                    if (slot_live[i]) begin
                        new_rank[i] = hit[i] ? 0 : hits;
                        for (int j = 0; j < SLOTS; j++)
                            if (slot_live[j] && hit[j] == hit[i] && slot_rank[j] < slot_rank[i])
                                new_rank[i]++;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                    slot_rank[i] = new_rank[i];
                note_report(RES_DONE, it.blk, hits > 0, 1'b1);
            end
            default: begin
                note_report(RES_DONE, it.blk, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Command driver.
    int send_gap = 0;
    always @(posedge i_clk) begin
        cmd_item_t it;
        logic      next_valid;
        if (!i_rst_n) begin
            i_cmd_valid <= 1'b0;
        end else begin
            if (i_cmd_valid && o_cmd_ready)
                predict_command('{i_command, i_block_number, i_block_size});
            if (!i_cmd_valid || o_cmd_ready) begin
                next_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cmds.size() > 0) begin
                    if (idling_on && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 12) - 1;
                    end else begin
                        it = pending_cmds.pop_front();
                        i_command      <= it.cmd;
                        i_block_number <= it.blk;
                        i_block_size   <= it.size;
                        next_valid = 1'b1;
                    end
                end
                i_cmd_valid <= next_valid;
            end
        end
    end

    // Result receiver: random stall bursts, plus the long hold-off on request.
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else if (holds_started < holds_wanted) begin
            holds_started++;
            hold_left = LONG_HOLD - 1;
            i_res_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_res_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        report_t want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d block %h found %0d bytes %h last %0d",
                             o_result_kind, o_result_block, o_found, o_bytes_in_use, o_last);
            end else begin
                want = expected_reports.pop_front();
                if (o_result_kind !== want.kind || o_result_block !== want.blk ||
                    o_found !== want.found || o_bytes_in_use !== want.bytes ||
                    o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result mismatch at cycle %0d", cycle_count);
                        $display("  expected: kind %0d block %h found %0d bytes %h last %0d",
                                 want.kind, want.blk, want.found, want.bytes, want.last);
                        $display("  actual:   kind %0d block %h found %0d bytes %h last %0d",
                                 o_result_kind, o_result_block, o_found, o_bytes_in_use,
                                 o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("size_budget_lru_tracker_test: errors");
            $finish;
        end
    end

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [BLOCK_W-1:0] blk,
                             logic [BYTES_W-1:0] size);
        pending_cmds.push_back('{cmd, blk, size});
    endtask

    // Mostly known block numbers so that free and touch find matches.
    task automatic queue_random(int count, int scale);
        cmd_item_t it;
        int        pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                it.cmd = CMD_ALLOC;
            else if (pick < 70)
                it.cmd = CMD_FREE;
            else if (pick < 95)
                it.cmd = CMD_TOUCH;
            else
                it.cmd = CMD_UNUSED;
            if ($urandom_range(0, 9) < 7)
                it.blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                it.blk = BLOCK_W'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                it.size = '0;
            else if (pick == 1)
                it.size = BYTES_W'($urandom);
            else
                it.size = BYTES_W'($urandom_range(0, scale));
            pending_cmds.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || i_cmd_valid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [BYTES_W-1:0] value);
        i_cfg_valid       <= 1'b1;
        i_cfg_byte_budget <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        budget_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [BLOCK_W-1:0] base;

        for (int i = 0; i < POOL_SIZE; i += 2) begin
            if (i % 6 == 0) begin
                // A pair of segment aliases.
                base = SEG_LO_BASE + BLOCK_W'($urandom_range(0, 20'h1FFFF));
                block_pool[i]     = base;
                block_pool[i + 1] = base + SEG_STEP;
            end else begin
                block_pool[i]     = BLOCK_W'($urandom);
                block_pool[i + 1] = BLOCK_W'($urandom);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_budget(25'h10000);
        queue_cmd(CMD_ALLOC,  20'h00000, 25'h0);
        queue_cmd(CMD_ALLOC,  20'hFFFFF, 25'h4000);
        queue_cmd(CMD_ALLOC,  20'h80010, 25'h2000);
        queue_cmd(CMD_ALLOC,  20'hA0010, 25'h2000);
        queue_cmd(CMD_ALLOC,  20'h00123, 25'h1000);
        queue_cmd(CMD_ALLOC,  20'h00123, 25'h1000);
        queue_cmd(CMD_TOUCH,  20'h80010, 25'h0);
        queue_cmd(CMD_TOUCH,  20'hA0010, 25'h0);
        queue_cmd(CMD_TOUCH,  20'h9FFFF, 25'h0);
        queue_cmd(CMD_TOUCH,  20'h7FFFF, 25'h0);
        queue_cmd(CMD_TOUCH,  20'hC0000, 25'h0);
        queue_cmd(CMD_FREE,   20'h00123, 25'h0);
        queue_cmd(CMD_FREE,   20'h55555, 25'h0);
        queue_cmd(CMD_UNUSED, 20'hFFFFF, BYTES_MAX);
        queue_cmd(CMD_ALLOC,  20'h00200, 25'h8000);
        // Larger than the budget: everything is evicted first.
        queue_cmd(CMD_ALLOC,  20'h00300, BYTES_MAX);
        queue_cmd(CMD_ALLOC,  20'h00400, 25'h0);
        queue_cmd(CMD_ALLOC,  20'h00500, 25'h10000);
        queue_cmd(CMD_FREE,   20'h00500, 25'h0);
        queue_cmd(CMD_FREE,   20'h00500, 25'h0);
        queue_cmd(CMD_TOUCH,  20'hBFFFF, 25'h0);
        queue_cmd(CMD_ALLOC,  20'hBFFFF, 25'h100);
        queue_cmd(CMD_TOUCH,  20'h9FFFF, 25'h0);
        wait_drained();

        write_budget(BUDGET_RESET);
        queue_random(60, 25'h80000);
        wait_drained();

        // Small sizes under the largest budget fill every slot. The receiver holds
        // off for a long stretch at the start so the tracker backs up.
        write_budget(BYTES_MAX);
        holds_wanted = 1;
        queue_random(50, 25'h10000);
        wait_drained();

        write_budget('0);
        queue_random(30, 25'h100);
        wait_drained();

        base = BLOCK_W'($urandom_range(0, 18));
        write_budget(BYTES_W'($urandom_range(25'h1000, 25'h400000)));
        queue_random(30, budget_limit / 3);
        wait_drained();
        queue_random(30, budget_limit / 3);
        wait_drained();

        idling_on = 1'b0;
        write_budget(25'h20000);
        queue_random(70, 25'h8000);
        wait_drained();

        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("size_budget_lru_tracker_test: clean");
        end else begin
            $display("size_budget_lru_tracker_test: errors");
        end
        $finish;
    end

endmodule
